/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the text screen block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock edge outside reset
`define TST_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked in the next cycle
`define TST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tst_pkg.sv */
// ----------------------------------------------------------------------------
// tst_pkg
// types, codes and helpers for the text screen block
// ----------------------------------------------------------------------------
package tst_pkg;

    localparam int CELLS = 1024;
    localparam int ADDR_W = 10;

    localparam logic [7:0] CELL_BLANK = 8'd32;
    localparam logic [7:0] RUN_BASE = 8'd192;
    localparam logic [7:0] GLYPH_RESET = 8'd95;
    localparam logic [7:0] GFX_BASE = 8'd128;
    localparam logic [9:0] ROW_LAST_BASE = 10'd960;
    localparam logic [9:0] CELL_LAST = 10'd1023;
    localparam logic [5:0] PY_MAX = 6'd47;

    localparam logic [2:0] OP_PUT = 3'd0;
    localparam logic [2:0] OP_SET_CUR = 3'd1;
    localparam logic [2:0] OP_TAB = 3'd2;
    localparam logic [2:0] OP_ZONE = 3'd3;
    localparam logic [2:0] OP_PX_SET = 3'd4;
    localparam logic [2:0] OP_PX_RES = 3'd5;
    localparam logic [2:0] OP_PX_TEST = 3'd6;
    localparam logic [2:0] OP_READ = 3'd7;

    localparam logic [7:0] CC_BS = 8'd8;
    localparam logic [7:0] CC_LF = 8'd10;
    localparam logic [7:0] CC_CR = 8'd13;
    localparam logic [7:0] CC_CUR_ON = 8'd14;
    localparam logic [7:0] CC_CUR_OFF = 8'd15;
    localparam logic [7:0] CC_SPECIAL = 8'd21;
    localparam logic [7:0] CC_WIDE = 8'd23;
    localparam logic [7:0] CC_LEFT = 8'd24;
    localparam logic [7:0] CC_RIGHT = 8'd25;
    localparam logic [7:0] CC_DOWN = 8'd26;
    localparam logic [7:0] CC_UP = 8'd27;
    localparam logic [7:0] CC_HOME = 8'd28;
    localparam logic [7:0] CC_CLR_LINE = 8'd29;
    localparam logic [7:0] CC_CLR_EOL = 8'd30;
    localparam logic [7:0] CC_CLR_EOS = 8'd31;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_LIFT,
        ST_EXEC,
        ST_PRINT,
        ST_SCROLL,
        ST_FILL,
        ST_DRAW_RD,
        ST_DRAW_WR,
        ST_PX_RD,
        ST_PX_MOD,
        ST_RD_CELL,
        ST_RD_CAP,
        ST_FINISH
    } state_t;

    // y / 3 for y below 48 by reciprocal multiply
    function automatic logic [3:0] div3(input logic [5:0] y);
        logic [12:0] p;
        p = 13'(y) * 13'd43;
        return p[10:7];
    endfunction

    function automatic logic [1:0] mod3(input logic [5:0] y);
        logic [5:0] q3;
        q3 = 6'(div3(y)) * 6'd3;
        return 2'(y - q3);
    endfunction

endpackage

/* rtl/tst_if.sv */
// ----------------------------------------------------------------------------
// tst_in_if / tst_out_if
// valid/ready channels carrying command and result beats
// ----------------------------------------------------------------------------
interface tst_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [7:0] char_code;
    logic [9:0] position;
    logic [6:0] pixel_x;
    logic [5:0] pixel_y;
    modport source (output valid, opcode, char_code, position, pixel_x, pixel_y,
                    input ready);
    modport sink (input valid, opcode, char_code, position, pixel_x, pixel_y,
                  output ready);
endinterface

interface tst_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] cell_value;
    logic       pixel_lit;
    logic [9:0] cursor_position;
    logic       wide_mode;
    modport source (output valid, cell_value, pixel_lit, cursor_position, wide_mode,
                    input ready);
    modport sink (input valid, cell_value, pixel_lit, cursor_position, wide_mode,
                  output ready);
endinterface

/* rtl/tst_ram.sv */
// ----------------------------------------------------------------------------
// tst_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module tst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

/* rtl/text_screen_terminal_with_block_graphics.sv */
// ----------------------------------------------------------------------------
// text_screen_terminal_with_block_graphics
// 64x16 character screen controller with cursor overlay and 2x3 block pixels
// ----------------------------------------------------------------------------
// The screen is one 1024 x 8 ram; a sequencer walks each command through it,
// one ram write and one ram read a cycle, and takes one command beat at a
// time. After reset the block zeroes the ram before it takes its first
// command. Runs of spaces (space codes, tab, next zone) are printed one cell
// at a time. Line clears blank one cell per cycle; clear to end of screen
// sweeps from the cursor to the last cell. Every scroll, from a newline on
// the last row or from printing past the last cell, copies rows up through
// the ram's read port and then blanks the last row. The result beat is held
// in an output register, so a stalled consumer only holds the block once the
// next result is ready.
module text_screen_terminal_with_block_graphics (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [7:0]       cfg_wdata,
    tst_in_if.sink           in_ch,
    tst_out_if.source        out_ch
);
    import tst_pkg::*;

    `include "assert_macros.svh"

    state_t      state_reg, state_next;

    // cursor and mode state
    logic [9:0]  cur_reg, cur_next;
    logic        shown_reg, shown_next;
    logic [7:0]  under_reg, under_next;
    logic        dw_reg, dw_next;
    logic        spec_reg, spec_next;
    logic [7:0]  glyph_reg;

    // latched command beat
    logic [2:0]  op_reg, op_next;
    logic [7:0]  ch_reg, ch_next;
    logic [9:0]  pos_reg, pos_next;
    logic [6:0]  px_reg, px_next;
    logic [5:0]  py_reg, py_next;

    // sequencer work registers
    logic [9:0]  rem_reg, rem_next;     // characters still to print
    logic [7:0]  pch_reg, pch_next;     // code being printed
    logic [9:0]  fill_reg, fill_next;   // fill and clear sweep address
    logic [9:0]  fend_reg, fend_next;   // last address of the sweep
    logic [10:0] scr_reg, scr_next;     // scroll read address

    // result
    logic [7:0]  cellv_reg, cellv_next;
    logic        lit_reg, lit_next;
    logic        ov_reg, ov_next;
    logic [7:0]  ocell_reg, ocell_next;
    logic        olit_reg, olit_next;
    logic [9:0]  ocur_reg, ocur_next;
    logic        odw_reg, odw_next;

    // ram port
    logic        ram_we;
    logic [9:0]  ram_waddr;
    logic [7:0]  ram_wdata;
    logic [9:0]  ram_raddr;
    logic [7:0]  ram_rdata;

    logic        in_beat;
    logic        is_ctrl;
    logic        is_run;
    logic        last_row;
    logic [5:0]  col;
    logic [10:0] print_sum;
    logic        can_finish;
    logic [9:0]  px_cell;
    logic [7:0]  px_bit;
    logic [7:0]  px_code;
    logic [10:0] scr_waddr;

    assign in_beat    = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign is_ctrl    = (ch_reg < CELL_BLANK);
    assign is_run     = (ch_reg >= RUN_BASE) && !spec_reg;
    assign last_row   = (cur_reg[9:6] == 4'hf);
    assign col        = cur_reg[5:0];
    assign print_sum  = 11'(cur_reg) + 11'd1 + 11'(dw_reg);
    assign can_finish = !ov_reg || out_ch.ready;
    assign scr_waddr  = scr_reg - 11'd65;

    // block graphics cell address and bit
    assign px_cell = {div3(py_reg), px_reg[6:1]};
    assign px_bit  = 8'd1 << (3'(px_reg[0]) + 3'({mod3(py_reg), 1'b0}));
    assign px_code = (ram_rdata[7:6] == 2'b10) ? ram_rdata : GFX_BASE;

    tst_ram #(
        .WIDTH(8),
        .DEPTH(CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLR:
            begin
                if (fill_reg == CELL_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    unique case (in_ch.opcode)
                        OP_PUT, OP_SET_CUR, OP_TAB, OP_ZONE: state_next = ST_LIFT;
                        OP_PX_SET, OP_PX_RES, OP_PX_TEST:
                            state_next = (in_ch.pixel_y > PY_MAX) ? ST_FINISH : ST_PX_RD;
                        default: state_next = ST_RD_CELL;
                    endcase
                end
            end
            ST_LIFT: state_next = ST_EXEC;
            ST_EXEC:
            begin
                unique case (op_reg)
                    OP_TAB:  state_next = (pos_reg > 10'(col)) ? ST_PRINT : ST_DRAW_RD;
                    OP_ZONE: state_next = ST_PRINT;
                    OP_PUT:
                    begin
                        if (!is_ctrl)
                        begin
                            state_next = ST_PRINT;
                        end
                        else if (ch_reg == CC_LF || ch_reg == CC_CR)
                        begin
                            state_next = last_row ? ST_SCROLL : ST_FILL;
                        end
                        else if (ch_reg == CC_CLR_LINE || ch_reg == CC_CLR_EOL ||
                                 ch_reg == CC_CLR_EOS)
                        begin
                            state_next = ST_FILL;
                        end
                        else
                        begin
                            state_next = ST_DRAW_RD;
                        end
                    end
                    default: state_next = ST_DRAW_RD;
                endcase
            end
            ST_PRINT:
            begin
                if (rem_reg == '0)
                begin
                    state_next = ST_DRAW_RD;
                end
                else if (print_sum[10])
                begin
                    state_next = ST_SCROLL;
                end
            end
            ST_SCROLL:
            begin
                if (scr_reg == 11'(CELLS))
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (fill_reg == fend_reg)
                begin
                    state_next = ST_PRINT;
                end
            end
            ST_DRAW_RD: state_next = shown_reg ? ST_DRAW_WR : ST_FINISH;
            ST_DRAW_WR: state_next = ST_FINISH;
            ST_PX_RD:   state_next = ST_PX_MOD;
            ST_PX_MOD:  state_next = ST_FINISH;
            ST_RD_CELL: state_next = ST_RD_CAP;
            ST_RD_CAP:  state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (can_finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb
    begin
        cur_next   = cur_reg;
        shown_next = shown_reg;
        under_next = under_reg;
        dw_next    = dw_reg;
        spec_next  = spec_reg;
        op_next    = op_reg;
        ch_next    = ch_reg;
        pos_next   = pos_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        rem_next   = rem_reg;
        pch_next   = pch_reg;
        fill_next  = fill_reg;
        fend_next  = fend_reg;
        scr_next   = scr_reg;
        cellv_next = cellv_reg;
        lit_next   = lit_reg;
        ov_next    = ov_reg && !out_ch.ready;
        ocell_next = ocell_reg;
        olit_next  = olit_reg;
        ocur_next  = ocur_reg;
        odw_next   = odw_reg;
        ram_we     = 1'b0;
        ram_waddr  = cur_reg;
        ram_wdata  = CELL_BLANK;
        ram_raddr  = cur_reg;

        unique case (state_reg)
            ST_CLR:
            begin
                ram_we    = 1'b1;
                ram_waddr = fill_reg;
                ram_wdata = '0;
                fill_next = fill_reg + 10'd1;
            end
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    op_next    = in_ch.opcode;
                    ch_next    = in_ch.char_code;
                    pos_next   = in_ch.position;
                    px_next    = in_ch.pixel_x;
                    py_next    = in_ch.pixel_y;
                    cellv_next = '0;
                    lit_next   = 1'b0;
                end
            end
            ST_LIFT:
            begin
                // put back the cell hidden under the cursor
                ram_we    = shown_reg;
                ram_wdata = under_reg;
            end
            ST_EXEC:
            begin
                rem_next = '0;
                pch_next = CELL_BLANK;
                unique case (op_reg)
                    OP_SET_CUR: cur_next = pos_reg;
                    OP_TAB:     rem_next = pos_reg - 10'(col);
                    OP_ZONE:    rem_next = 10'd16 - 10'(cur_reg[3:0]);
                    OP_PUT:
                    begin
                        if (is_run)
                        begin
                            rem_next = 10'(ch_reg - RUN_BASE);
                        end
                        else if (!is_ctrl)
                        begin
                            rem_next = 10'd1;
                            pch_next = ch_reg;
                        end
                        else
                        begin
                            unique case (ch_reg)
                                CC_BS:
                                begin
                                    cur_next  = cur_reg - 10'd1 - 10'(dw_reg);
                                    ram_we    = 1'b1;
                                    ram_waddr = cur_next;
                                end
                                CC_LF, CC_CR:
                                begin
                                    if (last_row)
                                    begin
                                        cur_next = ROW_LAST_BASE;
                                        scr_next = 11'd64;
                                    end
                                    else
                                    begin
                                        cur_next  = {cur_reg[9:6] + 4'd1, 6'd0};
                                        fill_next = cur_next;
                                        fend_next = {cur_reg[9:6] + 4'd1, 6'h3f};
                                    end
                                end
                                CC_CUR_ON:  shown_next = 1'b1;
                                CC_CUR_OFF: shown_next = 1'b0;
                                CC_SPECIAL: spec_next = !spec_reg;
                                CC_WIDE:
                                begin
                                    dw_next  = 1'b1;
                                    cur_next = (cur_reg + 10'd1) & 10'h3fe;
                                end
                                CC_LEFT:
                                    cur_next = {cur_reg[9:6], col - 6'd1 - 6'(dw_reg)};
                                CC_RIGHT:
                                    cur_next = {cur_reg[9:6], col + 6'd1 + 6'(dw_reg)};
                                CC_DOWN: cur_next = cur_reg + 10'd64;
                                CC_UP:   cur_next = cur_reg - 10'd64;
                                CC_HOME:
                                begin
                                    dw_next  = 1'b0;
                                    cur_next = '0;
                                end
                                CC_CLR_LINE:
                                begin
                                    cur_next  = {cur_reg[9:6], 6'd0};
                                    fill_next = {cur_reg[9:6], 6'd0};
                                    fend_next = {cur_reg[9:6], 6'h3f};
                                end
                                CC_CLR_EOL:
                                begin
                                    fill_next = cur_reg;
                                    fend_next = {cur_reg[9:6], 6'h3f};
                                end
                                CC_CLR_EOS:
                                begin
                                    fill_next = cur_reg;
                                    fend_next = CELL_LAST;
                                end
                                default: ;
                            endcase
                        end
                    end
                    default: ;
                endcase
            end
            ST_PRINT:
            begin
                if (rem_reg != '0)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = pch_reg;
                    rem_next  = rem_reg - 10'd1;
                    if (print_sum[10])
                    begin
                        cur_next = ROW_LAST_BASE;
                        scr_next = 11'd64;
                    end
                    else
                    begin
                        cur_next = print_sum[9:0];
                    end
                end
            end
            ST_SCROLL:
            begin
                // read one row ahead, write the word read last cycle
                ram_raddr = scr_reg[9:0];
                ram_we    = (scr_reg != 11'd64);
                ram_waddr = scr_waddr[9:0];
                ram_wdata = ram_rdata;
                scr_next  = scr_reg + 11'd1;
                fill_next = ROW_LAST_BASE;
                fend_next = CELL_LAST;
            end
            ST_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = fill_reg;
                fill_next = fill_reg + 10'd1;
            end
            ST_DRAW_RD: ;
            ST_DRAW_WR:
            begin
                under_next = ram_rdata;
                ram_we     = 1'b1;
                ram_wdata  = glyph_reg;
            end
            ST_PX_RD: ram_raddr = px_cell;
            ST_PX_MOD:
            begin
                ram_waddr = px_cell;
                if (op_reg == OP_PX_SET)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = px_code | px_bit;
                end
                else if (op_reg == OP_PX_RES)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = px_code & ~px_bit;
                end
                else
                begin
                    lit_next = |(px_code & px_bit);
                end
            end
            ST_RD_CELL: ram_raddr = pos_reg;
            ST_RD_CAP:  cellv_next = ram_rdata;
            ST_FINISH:
            begin
                if (can_finish)
                begin
                    ov_next    = 1'b1;
                    ocell_next = cellv_reg;
                    olit_next  = lit_reg;
                    ocur_next  = cur_reg;
                    odw_next   = dw_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
            cur_reg   <= '0;
            shown_reg <= 1'b0;
            under_reg <= '0;
            dw_reg    <= 1'b0;
            spec_reg  <= 1'b0;
            glyph_reg <= GLYPH_RESET;
            fill_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            shown_reg <= shown_next;
            under_reg <= under_next;
            dw_reg    <= dw_next;
            spec_reg  <= spec_next;
            fill_reg  <= fill_next;
            ov_reg    <= ov_next;
            if (cfg_we)
            begin
                glyph_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        ch_reg    <= ch_next;
        pos_reg   <= pos_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        rem_reg   <= rem_next;
        pch_reg   <= pch_next;
        fend_reg  <= fend_next;
        scr_reg   <= scr_next;
        cellv_reg <= cellv_next;
        lit_reg   <= lit_next;
        ocell_reg <= ocell_next;
        olit_reg  <= olit_next;
        ocur_reg  <= ocur_next;
        odw_reg   <= odw_next;
    end

    assign out_ch.valid           = ov_reg;
    assign out_ch.cell_value      = ocell_reg;
    assign out_ch.pixel_lit       = olit_reg;
    assign out_ch.cursor_position = ocur_reg;
    assign out_ch.wide_mode       = odw_reg;

    // no beat taken during the clearing pass or while a command is in work
    `TST_ASSERT_IMP(a_no_beat_busy, clk, rst_n, state_reg != ST_IDLE, !in_ch.ready,
        "command beat offered while busy")
    // an idle sequencer leaves the screen alone
    `TST_ASSERT_IMP(a_idle_no_write, clk, rst_n, state_reg == ST_IDLE, !ram_we,
        "screen write while idle")
    // pixel commands never move the cursor
    `TST_ASSERT_NEXT(a_px_cursor, clk, rst_n, state_reg == ST_PX_MOD,
        cur_reg == $past(cur_reg), "cursor moved by pixel command")
    // a result is only loaded when the output register is free
    `TST_ASSERT_NEXT(a_out_load, clk, rst_n,
        state_reg == ST_FINISH && ov_reg && !out_ch.ready, state_reg == ST_FINISH,
        "result dropped under backpressure")
endmodule
